### hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### hw/rtl/lwpm_pkg.sv
// shared types, constants and helpers for the lcd write to pixel mapper
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lwpm_pkg;

    localparam int SCREEN_ROWS    = 64;
    localparam int ROW_NIBBLES    = 34;
    localparam int SHADOW_COLUMNS = 36;

    localparam int ADDR_W     = 20;
    localparam int NIB_W      = 4;
    localparam int POS_W      = 6;
    localparam int LOFF_W     = 12;
    localparam int HOFF_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam int CELL_COUNT = SCREEN_ROWS * SHADOW_COLUMNS;
    localparam int CELL_AW    = $clog2(CELL_COUNT);
    localparam int CELL_W     = NIB_W + 1;

    localparam int DIV_STEPS = ADDR_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    localparam logic [ADDR_W-1:0] DISPLAY_START_MASK = 20'hffffe;
    localparam logic [HOFF_W-1:0] HORIZ_WIDE_LIMIT   = 3'd3;
    localparam logic [LOFF_W-1:0] HORIZ_WIDE_EXTRA   = 12'd2;
    localparam logic [POS_W-1:0]  LINES_DEFAULT      = 6'd63;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DISPLAY_START = 3'd0,
        REG_HORIZ_OFFSET  = 3'd1,
        REG_LINE_COUNT    = 3'd2,
        REG_LINE_OFFSET   = 3'd3,
        REG_MENU_START    = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic              cmd;
        logic [ADDR_W-1:0] address;
        logic [NIB_W-1:0]  nibble_value;
    } req_item_t;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
        logic [NIB_W-1:0] pixels;
        logic             last;
    } rsp_item_t;

    // one cell update, or a column fill over rows 0 .. lines-1
    typedef struct packed {
        logic             fill;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [NIB_W-1:0] val;
        logic [POS_W-1:0] lines;
    } cell_cmd_t;

    function automatic logic [CELL_AW-1:0] cell_addr(input logic [POS_W-1:0] row,
                                                     input logic [POS_W-1:0] col);
        logic [CELL_AW-1:0] base;
        base = CELL_AW'(row) * CELL_AW'(SHADOW_COLUMNS);
        return base + CELL_AW'(col);
    endfunction

endpackage

`default_nettype wire

### hw/rtl/lwpm_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module lwpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lwpm_front.sv
// front end: configuration registers, request intake, placement by iterative divide
// depends on lwpm_pkg
`timescale 1ns / 1ps
`default_nettype none

module lwpm_front (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    input  wire logic [lwpm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lwpm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                               req_valid,
    output logic                                    req_stall,
    input  wire lwpm_pkg::req_item_t                req_data,
    input  wire logic                               clearing,
    input  wire logic                               q_full,
    output logic                                    q_push,
    output lwpm_pkg::cell_cmd_t                     q_data
);

    import lwpm_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_CHECK,
        ST_PUSH
    } state_t;

    state_t state_reg;

    logic [ADDR_W-1:0] display_start_reg;
    logic [HOFF_W-1:0] horiz_offset_reg;
    logic [POS_W-1:0]  line_count_reg;
    logic [LOFF_W-1:0] line_offset_reg;
    logic [ADDR_W-1:0] menu_start_reg;

    logic [ADDR_W-1:0]    quot_reg;
    logic [LOFF_W-1:0]    rem_reg;
    logic [LOFF_W-1:0]    divisor_reg;
    logic                 menu_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    cell_cmd_t            cmd_reg;

    logic [POS_W-1:0]  lines;
    logic [LOFF_W-1:0] stride;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] off;
    logic              below;
    logic              accept;
    logic [LOFF_W:0]   rem_shift;
    logic              fits;
    logic [ADDR_W:0]   menu_row;
    logic              place_ok;
    logic [POS_W-1:0]  place_row;

    always_comb
    begin
        lines  = (line_count_reg == '0) ? LINES_DEFAULT : line_count_reg;
        stride = LOFF_W'(ROW_NIBBLES) + line_offset_reg +
                 ((horiz_offset_reg > HORIZ_WIDE_LIMIT) ? HORIZ_WIDE_EXTRA : '0);
        start  = req_data.cmd ? menu_start_reg : (display_start_reg & DISPLAY_START_MASK);
        below  = req_data.address < start;
        off    = req_data.address - start;
        accept = req_valid && !req_stall;

        // one restoring step per cycle
        rem_shift = {rem_reg, quot_reg[ADDR_W-1]};
        fits      = rem_shift >= {1'b0, divisor_reg};

        menu_row = (ADDR_W+1)'(cmd_reg.lines) + (ADDR_W+1)'(quot_reg) + (ADDR_W+1)'(1);
        if (menu_reg)
        begin
            place_ok  = (menu_row <= (ADDR_W+1)'(SCREEN_ROWS - 1)) &&
                        (rem_reg <= LOFF_W'(SHADOW_COLUMNS - 1));
            place_row = menu_row[POS_W-1:0];
        end
        else
        begin
            place_ok  = (quot_reg <= ADDR_W'(SCREEN_ROWS - 1)) &&
                        (rem_reg <= LOFF_W'(SHADOW_COLUMNS - 1));
            place_row = quot_reg[POS_W-1:0];
        end
    end

    assign req_stall = (state_reg != ST_IDLE) || clearing;
    assign q_push    = (state_reg == ST_PUSH) && !q_full;
    assign q_data    = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_start_reg <= '0;
            horiz_offset_reg  <= '0;
            line_count_reg    <= '0;
            line_offset_reg   <= '0;
            menu_start_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_DISPLAY_START: display_start_reg <= cfg_data[ADDR_W-1:0];
                REG_HORIZ_OFFSET:  horiz_offset_reg  <= cfg_data[HOFF_W-1:0];
                REG_LINE_COUNT:    line_count_reg    <= cfg_data[POS_W-1:0];
                REG_LINE_OFFSET:   line_offset_reg   <= cfg_data[LOFF_W-1:0];
                REG_MENU_START:    menu_start_reg    <= cfg_data[ADDR_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            quot_reg    <= '0;
            rem_reg     <= '0;
            divisor_reg <= '0;
            menu_reg    <= 1'b0;
            cmd_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && !below)
                    begin
                        cmd_reg.val   <= req_data.nibble_value;
                        cmd_reg.lines <= lines;
                        menu_reg      <= req_data.cmd;
                        if (!req_data.cmd && stride == '0)
                        begin
                            // zero stride: the offset is the column, fill every line
                            if (off <= ADDR_W'(SHADOW_COLUMNS - 1))
                            begin
                                cmd_reg.fill <= 1'b1;
                                cmd_reg.row  <= '0;
                                cmd_reg.col  <= off[POS_W-1:0];
                                state_reg    <= ST_PUSH;
                            end
                        end
                        else
                        begin
                            quot_reg    <= off;
                            rem_reg     <= '0;
                            cnt_reg     <= '0;
                            divisor_reg <= req_data.cmd ? LOFF_W'(ROW_NIBBLES) : stride;
                            state_reg   <= ST_DIVIDE;
                        end
                    end
                end
                ST_DIVIDE:
                begin
                    rem_reg  <= fits ? LOFF_W'(rem_shift - {1'b0, divisor_reg})
                                     : rem_shift[LOFF_W-1:0];
                    quot_reg <= {quot_reg[ADDR_W-2:0], fits};
                    cnt_reg  <= cnt_reg + DIV_CNT_W'(1);
                    if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    cmd_reg.fill <= 1'b0;
                    cmd_reg.row  <= place_row;
                    cmd_reg.col  <= rem_reg[POS_W-1:0];
                    state_reg    <= place_ok ? ST_PUSH : ST_IDLE;
                end
                ST_PUSH:
                begin
                    if (!q_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lwpm_cmd_queue.sv
// two-entry command queue between the placement front and the cell back end
// depends on lwpm_pkg
`timescale 1ns / 1ps
`default_nettype none

module lwpm_cmd_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire lwpm_pkg::cell_cmd_t  push_data,
    input  wire logic                 pop,
    output lwpm_pkg::cell_cmd_t       head,
    output logic                      full,
    output logic                      empty
);

    import lwpm_pkg::*;

    cell_cmd_t             entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_CNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign full    = count_reg == CMDQ_CNT_W'(CMDQ_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                              : wr_ptr_reg + CMDQ_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0
                              : rd_ptr_reg + CMDQ_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CMDQ_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CMDQ_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lwpm_back.sv
// back end: shadow cell memory, change detection and redraw output register
// depends on lwpm_pkg and lwpm_ram
`timescale 1ns / 1ps
`default_nettype none

module lwpm_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_empty,
    input  wire lwpm_pkg::cell_cmd_t  q_head,
    output logic                      q_pop,
    output logic                      clearing,
    output logic                      rsp_valid,
    input  wire logic                 rsp_stall,
    output lwpm_pkg::rsp_item_t       rsp_data
);

    import lwpm_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_FLUSH
    } state_t;

    state_t             state_reg;
    logic [CELL_AW-1:0] clr_cnt_reg;
    cell_cmd_t          cur_reg;
    logic               pend_valid_reg;
    rsp_item_t          pend_reg;
    logic               out_valid_reg;
    rsp_item_t          out_reg;

    logic               wr_en;
    logic [CELL_AW-1:0] wr_addr;
    logic [CELL_W-1:0]  wr_data;
    logic               rd_en;
    logic [CELL_AW-1:0] cur_addr;
    logic [CELL_W-1:0]  rd_data;
    logic [CELL_W-1:0]  want;
    logic               changed;
    logic               final_cell;
    logic               out_free;
    logic               hold;
    logic               out_load;
    rsp_item_t          out_next;

    always_comb
    begin
        cur_addr   = cell_addr(cur_reg.row, cur_reg.col);
        want       = {1'b1, cur_reg.val};
        changed    = rd_data != want;
        final_cell = !cur_reg.fill || (cur_reg.row == cur_reg.lines - POS_W'(1));
        out_free   = !out_valid_reg || !rsp_stall;
        // a second change cannot move the held result while the output is blocked
        hold       = changed && pend_valid_reg && !out_free;

        rd_en    = state_reg == ST_READ;
        wr_en    = (state_reg == ST_CLEAR) || ((state_reg == ST_CHECK) && !hold && changed);
        wr_addr  = (state_reg == ST_CLEAR) ? clr_cnt_reg : cur_addr;
        wr_data  = (state_reg == ST_CLEAR) ? '0 : want;

        out_next      = pend_reg;
        out_next.last = 1'b0;
        out_load      = 1'b0;
        if (state_reg == ST_CHECK && !hold && changed && pend_valid_reg)
        begin
            out_load = 1'b1;
        end
        else if (state_reg == ST_FLUSH && out_free)
        begin
            out_load      = 1'b1;
            out_next.last = 1'b1;
        end
    end

    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign clearing  = state_reg == ST_CLEAR;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    lwpm_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_shadow (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cur_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            cur_reg        <= '0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                out_reg       <= out_next;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + CELL_AW'(1);
                    if (clr_cnt_reg == CELL_AW'(CELL_COUNT - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (!q_empty)
                    begin
                        cur_reg   <= q_head;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    if (!hold)
                    begin
                        if (changed)
                        begin
                            pend_valid_reg <= 1'b1;
                            pend_reg       <= '{row: cur_reg.row, column: cur_reg.col,
                                                pixels: cur_reg.val, last: 1'b0};
                        end
                        if (final_cell)
                        begin
                            state_reg <= (changed || pend_valid_reg) ? ST_FLUSH : ST_IDLE;
                        end
                        else
                        begin
                            cur_reg.row <= cur_reg.row + POS_W'(1);
                            state_reg   <= ST_READ;
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (out_free)
                    begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lcd_write_to_pixel_mapper.sv
// Maps LCD controller memory writes to redraws of 4-bit screen cells held in a
// 64 x 36 shadow memory. After reset the shadow is swept clear one cell a cycle
// and no request transaction is taken meanwhile; configuration writes are taken
// at any time. A main-area write with a non-zero stride, and every menu-area
// write, is placed by a one-bit-per-cycle restoring divide of the 20-bit offset,
// so a request transaction occupies the front through accept, the divide steps,
// a range check and a queue push that waits on a full queue; a write that the
// range check drops skips the push; writes below the start address are dropped
// on accept. The back end pops a single-cell write, reads the shadow, compares
// and writes, then hands over the final result; a zero-stride column fill walks
// up to 63 rows, reading, comparing and writing each. A two-entry queue between
// front and back and a held result register let the front place the next write
// while the back end is still busy or the response side stalls. A write gives
// one response transaction per changed cell, the final one flagged with last.
// depends on lwpm_pkg, lwpm_front, lwpm_cmd_queue, lwpm_back
`timescale 1ns / 1ps
`default_nettype none

module lcd_write_to_pixel_mapper (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lwpm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lwpm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire lwpm_pkg::req_item_t             req_data,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output lwpm_pkg::rsp_item_t                  rsp_data
);

    import lwpm_pkg::*;

    cell_cmd_t push_data;
    cell_cmd_t head;
    logic      push;
    logic      pop;
    logic      full;
    logic      empty;
    logic      clearing;

    assign cfg_ready = 1'b1;

    lwpm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .clearing  (clearing),
        .q_full    (full),
        .q_push    (push),
        .q_data    (push_data)
    );

    lwpm_cmd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .full      (full),
        .empty     (empty)
    );

    lwpm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (empty),
        .q_head    (head),
        .q_pop     (pop),
        .clearing  (clearing),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

endmodule

`default_nettype wire

### hw/rtl/lwpm_checker.sv
// port-level checks for the lcd write to pixel mapper, bound to the top level
// depends on lwpm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lwpm_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            req_valid,
    input wire logic                            req_stall,
    input wire lwpm_pkg::req_item_t             req_data,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_stall,
    input wire lwpm_pkg::rsp_item_t             rsp_data
);

    import lwpm_pkg::*;

    // a stalled request transaction waits unchanged
    `ASSERT_NEXT(a_req_held, clk, rst_n, req_valid && req_stall, req_valid && $stable(req_data))

    // every reported cell lies inside the shadow width
    `ASSERT_IMPL(a_rsp_column_range, clk, rst_n, rsp_valid, rsp_data.column < POS_W'(SHADOW_COLUMNS))

    `ASSERT_NEXT(a_rsp_valid_held, clk, rst_n, rsp_valid && rsp_stall, rsp_valid)

    `ASSERT_NEXT(a_rsp_data_held, clk, rst_n, rsp_valid && rsp_stall, $stable(rsp_data))

endmodule

bind lcd_write_to_pixel_mapper lwpm_checker u_checker (.*);

`default_nettype wire
